@@ src/zts_pkg.sv @@
package zts_pkg;

	localparam int SIZE_W     = 5;
	localparam int BYTE_W     = 8;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd8;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_READ  = 4'b0010,
		ST_COPY  = 4'b0100,
		ST_DRAIN = 4'b1000
	} state_t;

	// walker control for the copy pass
	typedef struct packed {
		logic clear;
		logic step;
	} scan_ctl_t;

endpackage

@@ src/zts_ram.sv @@
module zts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ src/zts_scan.sv @@
module zts_scan #(
	parameter int MAX_SIDE = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  zts_pkg::scan_ctl_t                     ctl,
	input  logic [$clog2(MAX_SIDE+1)-1:0]          side,
	output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]   src_addr,
	output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]   dst_addr
);
	import zts_pkg::*;

	localparam int SIDE_W = $clog2(MAX_SIDE + 1);
	localparam int RC_W   = $clog2(MAX_SIDE);
	localparam int ADDR_W = $clog2(MAX_SIDE * MAX_SIDE);
	localparam int PROD_W = RC_W + SIDE_W;
	localparam int EXT_W  = RC_W + 1;

	logic [RC_W-1:0] zz_row_q, zz_col_q, sp_row_q, sp_col_q;
	logic [RC_W-1:0] zz_row_d, zz_col_d, sp_row_d, sp_col_d;
	logic [RC_W-1:0] last;
	logic [PROD_W-1:0] src_prod, dst_prod, src_sum, dst_sum;

	assign last = RC_W'(side - SIDE_W'(1));

	// zigzag: even anti-diagonal moves up-right, odd moves down-left
	always_comb begin
		zz_row_d = zz_row_q;
		zz_col_d = zz_col_q;
		if ((zz_row_q[0] ^ zz_col_q[0]) == 1'b0) begin
			if (zz_col_q == last) begin
				zz_row_d = zz_row_q + RC_W'(1);
			end else if (zz_row_q == '0) begin
				zz_col_d = zz_col_q + RC_W'(1);
			end else begin
				zz_row_d = zz_row_q - RC_W'(1);
				zz_col_d = zz_col_q + RC_W'(1);
			end
		end else begin
			if (zz_row_q == last) begin
				zz_col_d = zz_col_q + RC_W'(1);
			end else if (zz_col_q == '0) begin
				zz_row_d = zz_row_q + RC_W'(1);
			end else begin
				zz_row_d = zz_row_q + RC_W'(1);
				zz_col_d = zz_col_q - RC_W'(1);
			end
		end
	end

	// clockwise spiral, direction from position and ring
	always_comb begin
		logic [EXT_W-1:0] r, c, m, ring, far;
		r = EXT_W'(sp_row_q);
		c = EXT_W'(sp_col_q);
		m = EXT_W'(last);
		ring = r;
		if (c < ring) ring = c;
		if (m - r < ring) ring = m - r;
		if (m - c < ring) ring = m - c;
		far = m - ring;
		sp_row_d = sp_row_q;
		sp_col_d = sp_col_q;
		priority if (r == ring && c < far) begin
			sp_col_d = sp_col_q + RC_W'(1);
		end else if (c == far && r < far) begin
			sp_row_d = sp_row_q + RC_W'(1);
		end else if (r == far && c > ring) begin
			sp_col_d = sp_col_q - RC_W'(1);
		end else if (c == ring && r > ring + EXT_W'(1)) begin
			sp_row_d = sp_row_q - RC_W'(1);
		end else begin
			sp_col_d = sp_col_q + RC_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zz_row_q <= '0;
			zz_col_q <= '0;
			sp_row_q <= '0;
			sp_col_q <= '0;
		end else if (ctl.clear) begin
			zz_row_q <= '0;
			zz_col_q <= '0;
			sp_row_q <= '0;
			sp_col_q <= '0;
		end else if (ctl.step) begin
			zz_row_q <= zz_row_d;
			zz_col_q <= zz_col_d;
			sp_row_q <= sp_row_d;
			sp_col_q <= sp_col_d;
		end
	end

	// row * n + col
	assign src_prod = zz_row_q * side;
	assign dst_prod = sp_row_q * side;
	assign src_sum  = src_prod + PROD_W'(zz_col_q);
	assign dst_sum  = dst_prod + PROD_W'(sp_col_q);
	assign src_addr = ADDR_W'(src_sum);
	assign dst_addr = ADDR_W'(dst_sum);

endmodule

@@ src/zigzag_to_spiral_reorder_unit.sv @@
// Reorders an n-by-n byte matrix: the k-th element of the zigzag scan of the
// loaded matrix lands at the k-th place of a clockwise spiral starting at the
// top-left corner, and read items return the result in row-major order with
// row_end and frame_end marks. Send n*n load items (opcode 0) in row-major
// order, then n*n read items (opcode 1), each giving one result item. Loads
// on a full frame and reads before the frame is full are dropped and give no
// result. Loads can be taken back to back until the last of the frame. A read
// first presents the output-memory address, then moves the registered read
// data to the output register, and no new item is taken until it has; a read
// is held off while the output register holds an item that is not being taken.
// Accepting the last load starts the copy pass, which streams through both
// memories one element a cycle and holds in_ready low through the pass and
// the write-drain state that follows it. Writing matrix_size (only while
// idle) takes effect at once and restarts the frame; 0 acts as 1 and values
// above MAX_SIDE act as MAX_SIDE. The memories need no clearing after reset.
module zigzag_to_spiral_reorder_unit #(
	parameter int MAX_SIDE = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        matrix_size_we,
	input  logic [zts_pkg::SIZE_W-1:0]  matrix_size,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        opcode,
	input  logic [zts_pkg::BYTE_W-1:0]  load_byte,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [zts_pkg::BYTE_W-1:0]  out_byte,
	output logic                        row_end,
	output logic                        frame_end
);
	import zts_pkg::*;

	localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int SIDE_W = $clog2(MAX_SIDE + 1);
	localparam int RC_W   = $clog2(MAX_SIDE);

	state_t state_q;
	logic [SIZE_W-1:0] matrix_size_q;
	logic [CNT_W-1:0] load_count_q, read_count_q, copy_cnt_q;
	logic [RC_W-1:0] read_col_q;
	logic out_valid_q, row_end_q, frame_end_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic copy_vld_s1;
	logic [ADDR_W-1:0] dst_s1;

	logic [SIDE_W-1:0] side;
	logic [2*SIDE_W-1:0] side_sq;
	logic [CNT_W-1:0] total, total_m1;
	logic [RC_W-1:0] side_m1;
	logic in_accept, load_ok, read_ok, load_full, frame_done;
	scan_ctl_t scan_ctl;
	logic [ADDR_W-1:0] src_addr, dst_addr;
	logic [BYTE_W-1:0] in_rdata, out_rdata;

	// effective side length, clamped to 1..MAX_SIDE
	always_comb begin
		if (matrix_size_q == '0) begin
			side = SIDE_W'(1);
		end else if (32'(matrix_size_q) > MAX_SIDE) begin
			side = SIDE_W'(MAX_SIDE);
		end else begin
			side = SIDE_W'(matrix_size_q);
		end
	end

	assign side_sq  = side * side;
	assign total    = CNT_W'(side_sq);
	assign total_m1 = total - CNT_W'(1);
	assign side_m1  = RC_W'(side - SIDE_W'(1));

	assign load_full = (load_count_q == total);

	// a read only goes ahead once the output register is sure to be free
	assign in_ready  = (state_q == ST_IDLE) &&
		(opcode == OP_LOAD || !out_valid_q || out_ready);
	assign in_accept = in_valid && in_ready;
	assign load_ok   = in_accept && opcode == OP_LOAD && !load_full;
	assign read_ok   = in_accept && opcode == OP_READ && load_full;
	assign frame_done = (state_q == ST_READ) && (read_count_q == total_m1);

	// walkers restart with the frame and step through the copy pass
	always_comb begin
		scan_ctl.clear = matrix_size_we || frame_done ||
			(state_q == ST_COPY && copy_cnt_q == total_m1);
		scan_ctl.step  = (state_q == ST_COPY);
	end

	zts_scan #(
		.MAX_SIDE (MAX_SIDE)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (scan_ctl),
		.side     (side),
		.src_addr (src_addr),
		.dst_addr (dst_addr)
	);

	// input store: written by loads, read in zigzag order during the pass
	zts_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (DEPTH)
	) u_in_ram (
		.clk   (clk),
		.we    (load_ok),
		.waddr (load_count_q[ADDR_W-1:0]),
		.wdata (load_byte),
		.raddr (src_addr),
		.rdata (in_rdata)
	);

	// output store: written in spiral order in the cycle after the matching read,
	// read back in row-major order only after the drain state
	zts_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (DEPTH)
	) u_out_ram (
		.clk   (clk),
		.we    (copy_vld_s1),
		.waddr (dst_s1),
		.wdata (in_rdata),
		.raddr (read_count_q[ADDR_W-1:0]),
		.rdata (out_rdata)
	);

	// copy pipeline: destination travels alongside the input-store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			copy_vld_s1 <= 1'b0;
		end else begin
			copy_vld_s1 <= (state_q == ST_COPY);
		end
	end

	always_ff @(posedge clk) begin
		dst_s1 <= dst_addr;
	end

	// sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			matrix_size_q <= SIZE_RESET;
			load_count_q  <= '0;
			read_count_q  <= '0;
			read_col_q    <= '0;
			copy_cnt_q    <= '0;
		end else if (matrix_size_we) begin
			// new size restarts the frame
			matrix_size_q <= matrix_size;
			load_count_q  <= '0;
			read_count_q  <= '0;
			read_col_q    <= '0;
			copy_cnt_q    <= '0;
			state_q       <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (load_ok) begin
						load_count_q <= load_count_q + CNT_W'(1);
						if (load_count_q == total_m1) begin
							state_q <= ST_COPY;
						end
					end else if (read_ok) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_IDLE;
					if (frame_done) begin
						load_count_q <= '0;
						read_count_q <= '0;
						read_col_q   <= '0;
					end else begin
						read_count_q <= read_count_q + CNT_W'(1);
						read_col_q   <= (read_col_q == side_m1) ? '0 :
							read_col_q + RC_W'(1);
					end
				end
				ST_COPY: begin
					if (copy_cnt_q == total_m1) begin
						copy_cnt_q <= '0;
						state_q    <= ST_DRAIN;
					end else begin
						copy_cnt_q <= copy_cnt_q + CNT_W'(1);
					end
				end
				ST_DRAIN: begin
					// last pass write lands this cycle
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_READ) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			out_byte_q  <= out_rdata;
			row_end_q   <= (read_col_q == side_m1);
			frame_end_q <= (read_count_q == total_m1);
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign row_end   = row_end_q;
	assign frame_end = frame_end_q;

endmodule

@@ src/zts_checker.sv @@
module zts_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        opcode,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [zts_pkg::BYTE_W-1:0]  out_byte,
	input logic                        row_end,
	input logic                        frame_end
);
	import zts_pkg::*;

	// a read item is never taken while a waiting result is stuck
	a_read_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && opcode == OP_READ |-> !out_valid || out_ready)
		else $error("read accepted while output register blocked");

	// every new result traces back to an accepted read item, through the read state
	a_result_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && opcode == OP_READ, 2))
		else $error("result without a read item");

	// the last byte of a frame also closes a row
	a_frame_closes_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> row_end)
		else $error("frame_end without row_end");

	// stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
			$stable(row_end) && $stable(frame_end))
		else $error("result changed while stalled");

endmodule

bind zigzag_to_spiral_reorder_unit zts_checker u_zts_checker (.*);
